>>> rtl/u8r_pkg.sv
// Shared types, constants and code-point helpers for the UTF-8 repair block.
package u8r_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    localparam int COPY_W = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
    } t_out_word;

    // Up to three encoded bytes of one fallback code point, byte 0 first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_enc;

    // All output bytes caused by one input word
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            last;
    } t_job;

    typedef struct packed {
        logic held;
        logic copy_busy;
    } t_front_stat;

    function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20ac;
            5'd1:    cp = 16'h0020;
            5'd2:    cp = 16'h201a;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201e;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02c6;
            5'd9:    cp = 16'h02c6;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd13:   cp = 16'h0020;
            5'd14:   cp = 16'h007e;
            5'd15:   cp = 16'h007f;
            5'd16:   cp = 16'h0020;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201c;
            5'd20:   cp = 16'h201d;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02dc;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203a;
            5'd28:   cp = 16'h0153;
            5'd29:   cp = 16'h0020;
            5'd30:   cp = 16'h017e;
            5'd31:   cp = 16'h0178;
            default: cp = 16'h0020;
        endcase
        return cp;
    endfunction

    // Map a byte to its code point and encode it as UTF-8
    function automatic t_enc fallback_enc(input logic [7:0] b);
        logic [15:0] cp;
        t_enc        e;
        cp = (b[7:5] == 3'b100) ? cp1252_map(b[4:0]) : {8'h00, b};
        e  = '0;
        if (cp < 16'h0080) begin
            e.bytes[0] = cp[7:0];
            e.last_idx = 2'd0;
        end else if (cp < 16'h0800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.last_idx = 2'd1;
        end else begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.last_idx = 2'd2;
        end
        return e;
    endfunction

    // Bytes still to copy after a lead and its first continuation byte
    function automatic logic [COPY_W-1:0] copy_len(input logic [7:0] lead);
        logic [COPY_W-1:0] n;
        case (lead) inside
            [8'hE0:8'hEF]: n = COPY_W'(1);
            [8'hF0:8'hF7]: n = COPY_W'(2);
            [8'hF8:8'hFB]: n = COPY_W'(3);
            [8'hFC:8'hFD]: n = COPY_W'(4);
            [8'hFE:8'hFF]: n = COPY_W'(5);
            default:       n = '0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/u8r_front.sv
// Front end: classifies each input word and builds the job of output bytes it causes.
module u8r_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  u8r_pkg::t_in_word    i_in_word,
    output logic                 o_job_push,
    output u8r_pkg::t_job        o_job,
    output u8r_pkg::t_front_stat o_stat
);
    import u8r_pkg::*;

    logic              r_held;
    logic [7:0]        r_held_byte;
    logic [COPY_W-1:0] r_copy;
    logic              n_held;
    logic [7:0]        n_held_byte;
    logic [COPY_W-1:0] n_copy;
    logic              w_job_valid;
    t_job              w_job;
    t_enc              w_enc_held;
    t_enc              w_enc_new;
    logic [7:0]        w_b;
    logic              w_last;
    logic              w_ascii;
    logic              w_cont;

    assign w_b        = i_in_word.in_byte;
    assign w_last     = i_in_word.last_in;
    assign w_ascii    = ~w_b[7];
    assign w_cont     = (w_b[7:6] == 2'b10);
    assign w_enc_held = fallback_enc(r_held_byte);
    assign w_enc_new  = fallback_enc(w_b);

    always_comb begin
        n_held      = r_held;
        n_held_byte = r_held_byte;
        n_copy      = r_copy;
        w_job       = '0;
        w_job.last  = w_last;
        w_job_valid = 1'b0;
        if (r_copy != '0) begin
            w_job.bytes[0] = w_b;
            w_job.last_idx = 2'd0;
            w_job_valid    = 1'b1;
            n_copy         = COPY_W'(r_copy - COPY_W'(1));
        end else if (r_held) begin
            w_job_valid = 1'b1;
            n_held      = 1'b0;
            if (w_cont) begin
                w_job.bytes[0] = r_held_byte;
                w_job.bytes[1] = w_b;
                w_job.last_idx = 2'd1;
                n_copy         = copy_len(r_held_byte);
            end else begin
                // Flush the stale lead, then treat the new byte afresh
                w_job.bytes[0] = w_enc_held.bytes[0];
                w_job.bytes[1] = w_enc_held.bytes[1];
                if (w_ascii) begin
                    w_job.bytes[2] = w_b;
                    w_job.last_idx = 2'd2;
                end else if (w_last) begin
                    w_job.bytes[2] = w_enc_new.bytes[0];
                    w_job.bytes[3] = w_enc_new.bytes[1];
                    w_job.last_idx = 2'd3;
                end else begin
                    w_job.last_idx = 2'd1;
                    n_held         = 1'b1;
                    n_held_byte    = w_b;
                end
            end
        end else begin
            if (w_ascii) begin
                w_job.bytes[0] = w_b;
                w_job.last_idx = 2'd0;
                w_job_valid    = 1'b1;
            end else if (w_cont || w_last) begin
                w_job.bytes[2:0] = w_enc_new.bytes;
                w_job.last_idx   = w_enc_new.last_idx;
                w_job_valid      = 1'b1;
            end else begin
                n_held      = 1'b1;
                n_held_byte = w_b;
            end
        end
        if (w_last) begin
            n_copy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_copy <= '0;
        end else if (i_take) begin
            r_held <= n_held;
            r_copy <= n_copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte <= '0;
        end else if (i_take) begin
            r_held_byte <= n_held_byte;
        end
    end

    assign o_job_push       = i_take & w_job_valid;
    assign o_job            = w_job;
    assign o_stat.held      = r_held;
    assign o_stat.copy_busy = (r_copy != '0);

endmodule

>>> rtl/u8r_queue.sv
// Short job queue between front and back ends.
module u8r_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8r_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nempty,
    output u8r_pkg::t_job o_head
);
    import u8r_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign o_nempty = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign w_wr     = i_push & ~o_full;
    assign w_rd     = i_pop & o_nempty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + QPTR_W'(1));
            end
            if (w_rd) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + QPTR_W'(1));
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= QCNT_W'(r_count + QCNT_W'(1));
                2'b01:   r_count <= QCNT_W'(r_count - QCNT_W'(1));
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/u8r_back.sv
// Back end: walks the current job one byte per popped word.
module u8r_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nempty,
    input  u8r_pkg::t_job      i_q_head,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output u8r_pkg::t_out_word o_out_word
);
    import u8r_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_job       r_job;
    logic       w_fire;
    logic       w_end;
    logic       w_done;
    logic       w_load;

    assign w_fire  = i_pop & r_valid;
    assign w_end   = (r_idx == r_job.last_idx);
    assign w_done  = w_fire & w_end;
    assign w_load  = (~r_valid | w_done) & i_q_nempty;
    assign o_q_pop = w_load;
    assign o_empty = ~r_valid;

    assign o_out_word.out_byte   = r_job.bytes[r_idx];
    assign o_out_word.run_end    = w_end;
    assign o_out_word.stream_end = w_end & r_job.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_done) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_idx <= 2'(r_idx + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_q_head;
        end
    end

endmodule

>>> rtl/utf8_repair_cp1252_fallback_core.sv
// UTF-8 repair with a fallback table mostly following Windows-1252: top level.
// An accepted word's job is written into the job queue, then loaded into the back end's job
// register once the back end is free; that register's current byte drives the result ports.
// Throughput: one input word per cycle while the job queue has room; the back end emits one
// byte per cycle while pop is asserted, so a word causing up to four bytes holds it until all are popped.
// full rises when the four-entry job queue fills. Synchronous active-low reset empties
// the queue and drops any held lead byte or pending verbatim copy.
module utf8_repair_cp1252_fallback_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  u8r_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output u8r_pkg::t_out_word o_out_word
);
    import u8r_pkg::*;

    logic        w_take;
    logic        w_job_push;
    t_job        w_job;
    t_front_stat w_stat;
    logic        w_q_full;
    logic        w_q_nempty;
    logic        w_q_pop;
    t_job        w_q_head;

    assign full   = w_q_full;
    assign w_take = push & ~w_q_full;

    u8r_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_in_word  (i_in_word),
        .o_job_push (w_job_push),
        .o_job      (w_job),
        .o_stat     (w_stat)
    );

    u8r_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_job_push),
        .i_job    (w_job),
        .i_pop    (w_q_pop),
        .o_full   (w_q_full),
        .o_nempty (w_q_nempty),
        .o_head   (w_q_head)
    );

    u8r_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (w_q_nempty),
        .i_q_head   (w_q_head),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

    // End of stream leaves nothing held
    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in_word.last_in) |=> (!w_stat.held && !w_stat.copy_busy))
        else $error("lead or copy survives end of stream");

    a_held_xor_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.held && w_stat.copy_busy))
        else $error("lead held during verbatim copy");

    // A last word always yields a job
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in_word.last_in) |-> w_job_push)
        else $error("last word produced no output");

    a_stream_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.stream_end) |-> o_out_word.run_end)
        else $error("stream end without run end");

endmodule
